// File: design/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, codes and coefficient table for the 4:2:0 block to RGB core.
// ----------------------------------------------------------------------------
package y2r_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLOR_MODE  = 2'd0,
    CFG_FLIP_CHROMA = 2'd1
  } cfg_index_t;

  // coefficient sets
  typedef enum logic [1:0] {
    MODE_PC     = 2'd0,
    MODE_PAL    = 2'd1,
    MODE_V4L2   = 2'd2,
    MODE_NONE   = 2'd3
  } color_mode_t;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // chroma term width: product bits [19:10] of a 9 x 13 bit product
  localparam int unsigned TERM_W = 10;

  // chroma offset
  localparam logic [7:0] CHROMA_BIAS = 8'd128;

  typedef struct packed {
    logic [11:0] rv;
    logic [11:0] gu;
    logic [11:0] gv;
    logic [11:0] bu;
  } coef_t;

  // one converted block waiting for the pixel sequencer
  typedef struct packed {
    logic [3:0][7:0]          luma;  // in output order
    logic signed [TERM_W-1:0] rv;
    logic signed [TERM_W-1:0] gu;
    logic signed [TERM_W-1:0] gv;
    logic signed [TERM_W-1:0] bu;
  } block_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic coef_t coef_lookup(input color_mode_t mode);
    coef_t c;
    unique case (mode)
      MODE_PC:   c = '{rv: 12'd1632, gu: 12'd400, gv: 12'd528, bu: 12'd2064};
      MODE_PAL:  c = '{rv: 12'd1168, gu: 12'd408, gv: 12'd594, bu: 12'd2080};
      MODE_V4L2: c = '{rv: 12'd1440, gu: 12'd352, gv: 12'd736, bu: 12'd1816};
      MODE_NONE: c = '{rv: 12'd0,    gu: 12'd0,   gv: 12'd0,   bu: 12'd0};
      default:   c = '{rv: 12'd0,    gu: 12'd0,   gv: 12'd0,   bu: 12'd0};
    endcase
    return c;
  endfunction

  // clamp a signed channel sum to 0..255
  function automatic logic [7:0] sat8(input logic signed [11:0] x);
    logic [7:0] r;
    priority if (x[11])             r = 8'h00;
    else if (x > 12'sd255)          r = 8'hff;
    else                            r = x[7:0];
    return r;
  endfunction

endpackage

// File: design/y2r_front.sv
// ----------------------------------------------------------------------------
// y2r_front
// Accepts a 2x2 block, forms the four chroma terms and holds the result
// in one stage register until the queue takes it.
// ----------------------------------------------------------------------------
module y2r_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_luma_top_left,
  input  logic [7:0]                  in_luma_top_right,
  input  logic [7:0]                  in_luma_bottom_left,
  input  logic [7:0]                  in_luma_bottom_right,
  input  logic [7:0]                  in_chroma_first,
  input  logic [7:0]                  in_chroma_second,
  input  y2r_pkg::color_mode_t        color_mode,
  input  logic                        flip_chroma,
  input  y2r_pkg::queue_stat_t        q_stat,
  output logic                        q_push,
  output y2r_pkg::block_t             q_data
);
  import y2r_pkg::*;

  logic            valid_r, valid_nxt;
  block_t          entry_r, entry_nxt;
  logic            accept;
  logic signed [8:0]  first_s, second_s, u_s, v_s;
  logic signed [12:0] c_rv, c_gu, c_gv, c_bu;
  logic signed [21:0] p_rv, p_gu, p_gv, p_bu;
  coef_t           coef;

  // stage frees up when empty or when its beat moves into the queue
  assign q_push  = valid_r && !q_stat.full;
  assign accept  = in_push && (!valid_r || !q_stat.full);
  assign in_full = valid_r && q_stat.full;
  assign q_data  = entry_r;

  // chroma minus bias, roles chosen by flip bit
  assign first_s  = $signed({1'b0, in_chroma_first})  - $signed({1'b0, CHROMA_BIAS});
  assign second_s = $signed({1'b0, in_chroma_second}) - $signed({1'b0, CHROMA_BIAS});
  assign u_s      = flip_chroma ? first_s  : second_s;
  assign v_s      = flip_chroma ? second_s : first_s;

  // coefficient products, arithmetic shift by 10 is a bit-select
  assign coef = coef_lookup(color_mode);
  assign c_rv = $signed({1'b0, coef.rv});
  assign c_gu = $signed({1'b0, coef.gu});
  assign c_gv = $signed({1'b0, coef.gv});
  assign c_bu = $signed({1'b0, coef.bu});
  assign p_rv = v_s * c_rv;
  assign p_gu = u_s * c_gu;
  assign p_gv = v_s * c_gv;
  assign p_bu = u_s * c_bu;

  // next entry and stage occupancy
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (accept) begin
      entry_nxt.luma[0] = in_luma_top_left;
      entry_nxt.luma[1] = in_luma_bottom_left;
      entry_nxt.luma[2] = in_luma_top_right;
      entry_nxt.luma[3] = in_luma_bottom_right;
      entry_nxt.rv      = p_rv[19:10];
      entry_nxt.gu      = p_gu[19:10];
      entry_nxt.gv      = p_gv[19:10];
      entry_nxt.bu      = p_bu[19:10];
      valid_nxt         = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: design/y2r_fifo.sv
// ----------------------------------------------------------------------------
// y2r_fifo
// Short queue of converted blocks between the front and the pixel sequencer.
// ----------------------------------------------------------------------------
module y2r_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  y2r_pkg::block_t      push_data,
  input  logic                 pop,
  output y2r_pkg::block_t      head,
  output y2r_pkg::queue_stat_t stat
);
  import y2r_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  block_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot write
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// File: design/y2r_back.sv
// ----------------------------------------------------------------------------
// y2r_back
// Pixel sequencer: walks the four pixels of a block, one a cycle unless the
// output stalls, adds the chroma terms, saturates and registers each pixel.
// ----------------------------------------------------------------------------
module y2r_back (
  input  logic            clk,
  input  logic            rst_n,
  input  y2r_pkg::block_t q_head,
  input  logic            q_valid,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [1:0]      out_pixel_position,
  output logic            out_last_pixel
);
  import y2r_pkg::*;

  block_t       cur_r, cur_nxt;
  logic         cur_valid_r, cur_valid_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   red_r, green_r, blue_r;
  logic [1:0]   pos_r;
  logic         last_r;
  logic         emit, take, block_done;
  logic [7:0]   y;
  logic signed [11:0] y_s, red_s, green_s, blue_s;
  logic [7:0]   red_c, green_c, blue_c;

  // a pixel moves out whenever the output register is free or drained
  assign emit       = cur_valid_r && (!out_valid_r || out_pop);
  assign block_done = emit && (cnt_r == 2'd3);
  assign take       = q_valid && (!cur_valid_r || block_done);
  assign q_pop      = take;

  // channel arithmetic for the current pixel
  assign y       = cur_r.luma[cnt_r];
  assign y_s     = $signed({4'b0000, y});
  assign red_s   = y_s + 12'(cur_r.rv);
  assign green_s = y_s - 12'(cur_r.gu) - 12'(cur_r.gv);
  assign blue_s  = y_s + 12'(cur_r.bu);
  assign red_c   = (y == 8'd0) ? 8'h00 : sat8(red_s);
  assign green_c = (y == 8'd0) ? 8'h00 : sat8(green_s);
  assign blue_c  = (y == 8'd0) ? 8'h00 : sat8(blue_s);

  // sequencer control
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    if (take) begin
      cur_nxt       = q_head;
      cur_valid_nxt = 1'b1;
    end else if (block_done) begin
      cur_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      red_r   <= red_c;
      green_r <= green_c;
      blue_r  <= blue_c;
      pos_r   <= cnt_r;
      last_r  <= (cnt_r == 2'd3);
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_red            = red_r;
  assign out_green          = green_r;
  assign out_blue           = blue_r;
  assign out_pixel_position = pos_r;
  assign out_last_pixel     = last_r;

  // mid-block count only while a block is held
  a_cnt_has_block: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0) |-> cur_valid_r)
    else $error("pixel count set without a block");

  // fourth pixel wraps the count
  a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    block_done |=> (cnt_r == 2'd0))
    else $error("pixel count did not wrap after last pixel");

endmodule

// File: design/yuv420_block_to_rgb_core.sv
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_core
// Converts 2x2 blocks of 4:2:0 video to four RGB888 pixels each.
//
//   channel  | direction | handshake          | beat
//   ---------+-----------+--------------------+---------------------------
//   in_      | in        | in_push / in_full  | four luma, two chroma
//   out_     | out       | out_pop / out_empty| one pixel, position, last
//   cfg_     | in        | cfg_we             | register index and data
//
// One pixel leaves per cycle while the output is not stalled; blocks enter
// back to back while the two-entry queue has room. A block passes the front
// stage register, a queue slot and the sequencer's block register before
// its first pixel reaches the output register. Reset is synchronous, active
// low; it clears control state and sets color_mode and flip_chroma to zero.
// A stalled output holds the sequencer, the queue then fills and in_full rises.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_luma_top_left,
  input  logic [7:0] in_luma_top_right,
  input  logic [7:0] in_luma_bottom_left,
  input  logic [7:0] in_luma_bottom_right,
  input  logic [7:0] in_chroma_first,
  input  logic [7:0] in_chroma_second,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [1:0] out_pixel_position,
  output logic       out_last_pixel,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);
  import y2r_pkg::*;

  color_mode_t color_mode_r, color_mode_nxt;
  logic        flip_chroma_r, flip_chroma_nxt;
  queue_stat_t q_stat;
  logic        q_push, q_pop;
  block_t      q_in, q_head;

  // configuration registers
  always_comb begin
    color_mode_nxt  = color_mode_r;
    flip_chroma_nxt = flip_chroma_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:  color_mode_nxt  = color_mode_t'(cfg_data);
        CFG_FLIP_CHROMA: flip_chroma_nxt = cfg_data[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r  <= MODE_PC;
      flip_chroma_r <= 1'b0;
    end else begin
      color_mode_r  <= color_mode_nxt;
      flip_chroma_r <= flip_chroma_nxt;
    end
  end

  // front: accept and form chroma terms
  y2r_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_luma_top_left     (in_luma_top_left),
    .in_luma_top_right    (in_luma_top_right),
    .in_luma_bottom_left  (in_luma_bottom_left),
    .in_luma_bottom_right (in_luma_bottom_right),
    .in_chroma_first      (in_chroma_first),
    .in_chroma_second     (in_chroma_second),
    .color_mode           (color_mode_r),
    .flip_chroma          (flip_chroma_r),
    .q_stat               (q_stat),
    .q_push               (q_push),
    .q_data               (q_in)
  );

  // queue between front and back
  y2r_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // back: pixel sequencer and output register
  y2r_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_head),
    .q_valid            (!q_stat.empty),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_pixel_position (out_pixel_position),
    .out_last_pixel     (out_last_pixel)
  );

endmodule

// File: bench/yuv420_block_to_rgb_core_test.sv
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_core_test
// Self-checking bench for the 4:2:0 block to RGB core. A short table of
// directed blocks is followed by random blocks under three idling profiles.
// Every accepted block is expanded into four expected pixels by a local
// converter model. Each popped pixel beat is compared with the oldest one.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_core_test;
  import y2r_pkg::*;

  // register indexes that the block does not decode
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam int RANDOM_PER_PHASE = 157;
  localparam int PHASE_COUNT      = 3;
  localparam int SETTING_SPAN     = 40;
  localparam int TAIL_CYCLES      = 8;

  typedef struct packed {
    logic [7:0] tl;
    logic [7:0] tr;
    logic [7:0] bl;
    logic [7:0] br;
    logic [7:0] c_first;
    logic [7:0] c_second;
  } block_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] pos;
    logic       last;
  } pixel_t;

  // grey: expected pixel is its own luma on all three channels
  typedef struct packed {
    color_mode_t mode;
    logic        flip;
    block_in_t   blk;
    logic        grey;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // zero luma is black whatever the chroma
    '{MODE_PC,   1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0  }, 1'b1},
    // neutral chroma leaves luma alone
    '{MODE_PC,   1'b0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}, 1'b1},
    '{MODE_PC,   1'b0, '{8'd1,   8'd2,   8'd3,   8'd4,   8'd128, 8'd128}, 1'b1},
    '{MODE_PC,   1'b0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0},
    '{MODE_PC,   1'b0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0  }, 1'b0},
    '{MODE_PC,   1'b0, '{8'd1,   8'd1,   8'd1,   8'd1,   8'd0,   8'd255}, 1'b0},
    // rounding toward minus infinity, mixed with a zero luma
    '{MODE_PC,   1'b0, '{8'd0,   8'd255, 8'd128, 8'd1,   8'd127, 8'd129}, 1'b0},
    '{MODE_PAL,  1'b0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255}, 1'b0},
    '{MODE_PAL,  1'b0, '{8'd16,  8'd235, 8'd128, 8'd64,  8'd255, 8'd0  }, 1'b0},
    '{MODE_V4L2, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255}, 1'b0},
    '{MODE_V4L2, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1},
    '{MODE_V4L2, 1'b1, '{8'd200, 8'd50,  8'd100, 8'd150, 8'd200, 8'd60 }, 1'b0},
    '{MODE_PC,   1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0  }, 1'b0},
    '{MODE_PC,   1'b1, '{8'd1,   8'd1,   8'd1,   8'd1,   8'd0,   8'd255}, 1'b0},
    // no chroma terms: output is luma only
    '{MODE_NONE, 1'b0, '{8'd17,  8'd34,  8'd51,  8'd68,  8'd0,   8'd255}, 1'b1},
    '{MODE_NONE, 1'b0, '{8'd255, 8'd0,   8'd1,   8'd254, 8'd255, 8'd0  }, 1'b1},
    '{MODE_NONE, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd128, 8'd37,  8'd219}, 1'b1},
    '{MODE_PAL,  1'b1, '{8'd255, 8'd1,   8'd128, 8'd0,   8'd129, 8'd127}, 1'b0}
  };

  localparam logic [7:0] EDGE_VALUES [5] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  block_in_t  in_blk;
  logic       in_grey;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [1:0] out_pixel_position;
  logic       out_last_pixel;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [1:0] cfg_data;

  // converter settings as the block should hold them
  color_mode_t mode_q = MODE_PC;
  logic        flip_q = 1'b0;

  pixel_t pixel_q [$];
  int     mismatches    = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;

  yuv420_block_to_rgb_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_luma_top_left     (in_blk.tl),
    .in_luma_top_right    (in_blk.tr),
    .in_luma_bottom_left  (in_blk.bl),
    .in_luma_bottom_right (in_blk.br),
    .in_chroma_first      (in_blk.c_first),
    .in_chroma_second     (in_blk.c_second),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_red              (out_red),
    .out_green            (out_green),
    .out_blue             (out_blue),
    .out_pixel_position   (out_pixel_position),
    .out_last_pixel       (out_last_pixel),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #1 clk = ~clk;

  // clamp to an 8-bit channel
  function automatic logic [7:0] clamp8(input int x);
    if (x > 255) return 8'hff;
    if (x < 0) return 8'h00;
    return x[7:0];
  endfunction

  // expand one block into its four expected pixels
  function automatic void queue_block_pixels(input block_in_t b, input logic grey);
    int         u;
    int         v;
    int         k_rv;
    int         k_gu;
    int         k_gv;
    int         k_bu;
    int         t_rv;
    int         t_gu;
    int         t_gv;
    int         t_bu;
    int         y;
    logic [7:0] luma [4];
    pixel_t     px;
    v = flip_q ? int'(b.c_second) - 128 : int'(b.c_first) - 128;
    u = flip_q ? int'(b.c_first) - 128 : int'(b.c_second) - 128;
    case (mode_q)
      MODE_PC:   begin k_rv = 1632; k_gu = 400; k_gv = 528; k_bu = 2064; end
      MODE_PAL:  begin k_rv = 1168; k_gu = 408; k_gv = 594; k_bu = 2080; end
      MODE_V4L2: begin k_rv = 1440; k_gu = 352; k_gv = 736; k_bu = 1816; end
      default:   begin k_rv = 0;    k_gu = 0;   k_gv = 0;   k_bu = 0;    end
    endcase
    t_rv = (v * k_rv) >>> 10;
    t_gu = (u * k_gu) >>> 10;
    t_gv = (v * k_gv) >>> 10;
    t_bu = (u * k_bu) >>> 10;
    luma[0] = b.tl;
    luma[1] = b.bl;
    luma[2] = b.tr;
    luma[3] = b.br;
    for (int k = 0; k < 4; k++) begin
      y = luma[k];
      if (grey) begin
        px.red   = luma[k];
        px.green = luma[k];
        px.blue  = luma[k];
      end else if (y > 0) begin
        px.red   = clamp8(y + t_rv);
        px.green = clamp8(y - t_gu - t_gv);
        px.blue  = clamp8(y + t_bu);
      end else begin
        px.red   = 8'h00;
        px.green = 8'h00;
        px.blue  = 8'h00;
      end
      px.pos  = k[1:0];
      px.last = (k == 3);
      pixel_q.push_back(px);
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // record the expected pixels of each accepted block beat
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) queue_block_pixels(in_blk, in_grey);
  end

  // compare each popped pixel beat, then pick the next pop
  always @(posedge clk) begin : pixel_checker
    pixel_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with nothing expected: r %0d g %0d b %0d pos %0d",
               out_red, out_green, out_blue, out_pixel_position);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("pixel_position", want.pos, out_pixel_position);
        check_field("last_pixel", want.last, out_last_pixel);
      end
    end
    out_pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // offer one block beat, idling first at the sender's rate
  task automatic push_block(input block_in_t b, input logic grey);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_blk  <= b;
    in_grey <= grey;
    do @(posedge clk); while (in_full);
  endtask

  // hold the sender until every expected pixel has left
  task automatic drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_COLOR_MODE:  mode_q = color_mode_t'(data);
      CFG_FLIP_CHROMA: flip_q = data[0];
      default:         ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input color_mode_t mode, input logic [1:0] flip_word);
    drain();
    write_reg(CFG_COLOR_MODE, mode);
    write_reg(CFG_FLIP_CHROMA, flip_word);
  endtask

  // random sample, biased toward the range ends and the chroma midpoint
  function automatic logic [7:0] rand_sample();
    if ($urandom_range(0, 4) == 0) return EDGE_VALUES[$urandom_range(0, 4)];
    return 8'($urandom);
  endfunction

  initial begin : stimulus
    block_in_t b;
    int        setting;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_blk    = '0;
    in_grey   = 1'b0;
    out_pop   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, sender and receiver at the first profile
    send_idle_pct = 12;
    recv_idle_pct = 77;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].mode != mode_q || dir_rows[r].flip != flip_q)
        apply_setting(dir_rows[r].mode, {1'b0, dir_rows[r].flip});
      push_block(dir_rows[r].blk, dir_rows[r].grey);
    end

    // random blocks under each idling profile
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin send_idle_pct = 12; recv_idle_pct = 77; end
        1:       begin send_idle_pct = 77; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % SETTING_SPAN == 0) begin
          // walk all mode and flip pairs, upper data bit of flip is noise
          setting = (p * 4 + i / SETTING_SPAN) % 8;
          apply_setting(color_mode_t'(setting % 4),
                        {1'($urandom), 1'(setting / 4)});
          if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 2'($urandom));
        end
        b.tl       = rand_sample();
        b.tr       = rand_sample();
        b.bl       = rand_sample();
        b.br       = rand_sample();
        b.c_first  = rand_sample();
        b.c_second = rand_sample();
        push_block(b, 1'b0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("yuv420_block_to_rgb_core verification clean");
    end else begin
      $display("yuv420_block_to_rgb_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("yuv420_block_to_rgb_core verification failed");
    $finish;
  end

endmodule
